FILE: hw/rtl/u8d_pkg.sv
// Shared types and constants of the UTF-8 decoder.
package u8d_pkg;

   localparam int CpWidth   = 21;
   localparam int UsedWidth = 3;

   localparam logic [CpWidth-1:0]   REPL_CP   = 21'h00FFFD;
   localparam logic [CpWidth-1:0]   MIN_CP_2  = 21'h000080;
   localparam logic [CpWidth-1:0]   MIN_CP_3  = 21'h000800;
   localparam logic [CpWidth-1:0]   MIN_CP_4  = 21'h010000;
   localparam logic [CpWidth-1:0]   MAX_CP    = 21'h10FFFF;

   localparam logic [UsedWidth-1:0] LEN_NONE  = 3'd0;
   localparam logic [UsedWidth-1:0] LEN_ONE   = 3'd1;
   localparam logic [UsedWidth-1:0] LEN_TWO   = 3'd2;
   localparam logic [UsedWidth-1:0] LEN_THREE = 3'd3;
   localparam logic [UsedWidth-1:0] LEN_FOUR  = 3'd4;

   // Work for the back end made by one input byte: rep_count replacement
   // results (one byte each), then an optional tail result.
   typedef struct packed {
      logic [1:0]           rep_count;
      logic                 tail_valid;
      logic [CpWidth-1:0]   tail_cp;
      logic [UsedWidth-1:0] tail_used;
      logic                 tail_rep;
   } u8d_cmd_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } u8d_qstat_type;

endpackage

FILE: hw/rtl/u8d_channels.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u8d_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [u8d_pkg::CpWidth-1:0]     code_point;
   logic [u8d_pkg::UsedWidth-1:0]   bytes_used;
   logic                            replaced;
   logic                            last_of_run;

   modport source (output valid, output code_point, output bytes_used,
                   output replaced, output last_of_run, input ready);
   modport sink   (input valid, input code_point, input bytes_used,
                   input replaced, input last_of_run, output ready);
endinterface

FILE: hw/rtl/u8d_front.sv
// Front end: takes one byte per cycle while the command queue has room, tracks the open sequence and builds commands.
module u8d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           data_byte,
   input  logic                 final_byte,
   input  logic                 queue_not_full,
   output logic                 byte_ready,
   output logic                 cmd_push,
   output u8d_pkg::u8d_cmd_type cmd
);
   import u8d_pkg::*;

   logic [CpWidth-1:0]   value_acc_ff, value_acc_in;
   logic [UsedWidth-1:0] seq_length_ff, seq_length_in;
   logic [1:0]           bytes_held_ff, bytes_held_in;

   logic                 accept;
   logic                 is_cont;
   logic                 seq_open;
   logic [CpWidth-1:0]   acc_next;
   logic [2:0]           held_next;
   logic                 bad_value;

   assign byte_ready = queue_not_full;
   assign accept     = byte_valid && queue_not_full;
   assign is_cont    = (data_byte[7:6] == 2'b10);
   assign seq_open   = (seq_length_ff != LEN_NONE);
   assign acc_next   = {value_acc_ff[CpWidth-7:0], data_byte[5:0]};
   assign held_next  = {1'b0, bytes_held_ff} + 3'd1;

   always_comb begin
      unique case (seq_length_ff)
         LEN_TWO:   bad_value = (acc_next < MIN_CP_2);
         LEN_THREE: bad_value = (acc_next < MIN_CP_3);
         default:   bad_value = (acc_next < MIN_CP_4) || (acc_next > MAX_CP);
      endcase
   end

   always_comb begin
      cmd           = '0;
      value_acc_in  = value_acc_ff;
      seq_length_in = seq_length_ff;
      bytes_held_in = bytes_held_ff;
      if (seq_open && is_cont) begin
         if (held_next >= seq_length_ff) begin
            cmd.tail_valid = 1'b1;
            cmd.tail_cp    = bad_value ? REPL_CP : acc_next;
            cmd.tail_used  = seq_length_ff;
            cmd.tail_rep   = bad_value;
            value_acc_in   = '0;
            seq_length_in  = LEN_NONE;
            bytes_held_in  = '0;
         end else if (final_byte) begin
            // Text ends inside a sequence: every byte so far is replaced.
            cmd.rep_count  = held_next[1:0];
            value_acc_in   = '0;
            seq_length_in  = LEN_NONE;
            bytes_held_in  = '0;
         end else begin
            value_acc_in   = acc_next;
            bytes_held_in  = held_next[1:0];
         end
      end else begin
         // A sequence cut short by a non-continuation byte flushes its held bytes.
         cmd.rep_count = seq_open ? bytes_held_ff : 2'd0;
         value_acc_in  = '0;
         seq_length_in = LEN_NONE;
         bytes_held_in = '0;
         priority if (!data_byte[7]) begin
            cmd.tail_valid = 1'b1;
            cmd.tail_cp    = {{(CpWidth-8){1'b0}}, data_byte};
            cmd.tail_used  = LEN_ONE;
            cmd.tail_rep   = 1'b0;
         end else if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110 ||
                      data_byte[7:3] == 5'b11110) begin
            if (final_byte) begin
               // A lead byte that is also the last byte stands alone.
               cmd.tail_valid = 1'b1;
               cmd.tail_cp    = REPL_CP;
               cmd.tail_used  = LEN_ONE;
               cmd.tail_rep   = 1'b1;
            end else begin
               bytes_held_in = 2'd1;
               priority if (data_byte[7:5] == 3'b110) begin
                  value_acc_in  = {{(CpWidth-5){1'b0}}, data_byte[4:0]};
                  seq_length_in = LEN_TWO;
               end else if (data_byte[7:4] == 4'b1110) begin
                  value_acc_in  = {{(CpWidth-4){1'b0}}, data_byte[3:0]};
                  seq_length_in = LEN_THREE;
               end else begin
                  value_acc_in  = {{(CpWidth-3){1'b0}}, data_byte[2:0]};
                  seq_length_in = LEN_FOUR;
               end
            end
         end else begin
            cmd.tail_valid = 1'b1;
            cmd.tail_cp    = REPL_CP;
            cmd.tail_used  = LEN_ONE;
            cmd.tail_rep   = 1'b1;
         end
      end
   end

   assign cmd_push = accept && (cmd.tail_valid || (cmd.rep_count != 2'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         value_acc_ff  <= '0;
         seq_length_ff <= LEN_NONE;
         bytes_held_ff <= '0;
      end else if (accept) begin
         value_acc_ff  <= value_acc_in;
         seq_length_ff <= seq_length_in;
         bytes_held_ff <= bytes_held_in;
      end
   end

endmodule

FILE: hw/rtl/u8d_queue.sv
// Command queue between the front end and the back end.
module u8d_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  u8d_pkg::u8d_cmd_type   push_cmd,
   input  logic                   pop,
   output u8d_pkg::u8d_cmd_type   head_cmd,
   output u8d_pkg::u8d_qstat_type status
);
   import u8d_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   u8d_cmd_type     entries_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign status.not_empty = (count_ff != '0);
   assign status.not_full  = (count_ff != CW'(DEPTH));
   assign head_cmd         = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/u8d_back.sv
// Back end: expands each command into its result items through an output register.
module u8d_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  u8d_pkg::u8d_cmd_type          head_cmd,
   output logic                          cmd_pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [u8d_pkg::CpWidth-1:0]   out_code_point,
   output logic [u8d_pkg::UsedWidth-1:0] out_bytes_used,
   output logic                          out_replaced,
   output logic                          out_last
);
   import u8d_pkg::*;

   logic                 out_valid_ff, out_valid_in;
   logic [CpWidth-1:0]   code_point_ff, code_point_in;
   logic [UsedWidth-1:0] bytes_used_ff, bytes_used_in;
   logic                 replaced_ff, replaced_in;
   logic                 last_ff, last_in;
   logic [1:0]           idx_ff, idx_in;

   logic                 load;
   logic [2:0]           total;
   logic                 in_rep;

   assign total  = {1'b0, head_cmd.rep_count} + {2'b00, head_cmd.tail_valid};
   assign in_rep = (idx_ff < head_cmd.rep_count);
   assign load   = head_valid && (!out_valid_ff || out_ready);

   always_comb begin
      last_in       = (({1'b0, idx_ff} + 3'd1) == total);
      code_point_in = in_rep ? REPL_CP : head_cmd.tail_cp;
      bytes_used_in = in_rep ? LEN_ONE : head_cmd.tail_used;
      replaced_in   = in_rep ? 1'b1    : head_cmd.tail_rep;
      cmd_pop       = load && last_in;
      idx_in        = !load ? idx_ff : (last_in ? 2'd0 : idx_ff + 2'd1);
      out_valid_in  = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_point_ff <= code_point_in;
         bytes_used_ff <= bytes_used_in;
         replaced_ff   <= replaced_in;
         last_ff       <= last_in;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_code_point = code_point_ff;
   assign out_bytes_used = bytes_used_ff;
   assign out_replaced   = replaced_ff;
   assign out_last       = last_ff;

endmodule

FILE: hw/rtl/utf8_decoder_unit.sv
// Top level of the UTF-8 decoder: front end, command queue and back end.
//
//   Channel   Direction  Item carries
//   req_ch    in         data_byte[7:0], final_byte
//   rsp_ch    out        code_point[20:0], bytes_used[2:0], replaced, last_of_run
//
// The front end takes one byte per cycle while the command queue has room.
// A byte that makes no result (it opens or extends a sequence) leaves only state.
// The back end sends one result per cycle while rsp_ch.ready is high, so a byte
// that makes more than one result holds it up; the queue of QUEUE_DEPTH commands soaks up such bursts.
// Synchronous reset clears the open sequence, the queue and the output register.
// A low rsp_ch.ready holds the result; once the queue fills, req_ch.ready falls.
module utf8_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic      clock,
   input logic      reset,
   u8d_req_if.sink   req_ch,
   u8d_rsp_if.source rsp_ch
);
   import u8d_pkg::*;

   u8d_cmd_type   push_cmd;
   u8d_cmd_type   head_cmd;
   u8d_qstat_type q_status;
   logic          cmd_push;
   logic          cmd_pop;
   logic          byte_ready;

   // The front end decodes each byte and pushes a command for the back end when the byte makes results.
   u8d_front u_front (
      .clock          (clock),
      .reset          (reset),
      .byte_valid     (req_ch.valid),
      .data_byte      (req_ch.data_byte),
      .final_byte     (req_ch.final_byte),
      .queue_not_full (q_status.not_full),
      .byte_ready     (byte_ready),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   assign req_ch.ready = byte_ready;

   // Commands wait here so that a stalled output does not stop the input at once.
   u8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // The back end turns each command into one to four result items.
   u8d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_status.not_empty),
      .head_cmd       (head_cmd),
      .cmd_pop        (cmd_pop),
      .out_valid      (rsp_ch.valid),
      .out_ready      (rsp_ch.ready),
      .out_code_point (rsp_ch.code_point),
      .out_bytes_used (rsp_ch.bytes_used),
      .out_replaced   (rsp_ch.replaced),
      .out_last       (rsp_ch.last_of_run)
   );

   // The results of one byte come without a gap: more always follow a non-last one.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last_of_run |=> rsp_ch.valid)
      else $error("result run broken before its last item");

   // A replaced result always carries the replacement character.
   a_repl_value: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.replaced |-> rsp_ch.code_point == REPL_CP)
      else $error("replaced result with wrong code point");

   // Nothing is offered on the output right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result offered right after reset");

   // Every result stands for one to four source bytes.
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.bytes_used != LEN_NONE && rsp_ch.bytes_used <= LEN_FOUR)
      else $error("bytes_used out of range");

endmodule
